/* hw/rtl/ppa_pkg.sv */
// Shared types, codes and control structs of the per-CPU page allocator.
package ppa_pkg;

    // Operation codes
    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD     = 2'd1;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_STOP  = 1'd1;

    typedef struct packed {
        logic        func;
        logic [2:0]  cpu_id;
        logic [31:0] page_addr;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HEAD,
        ST_LINK
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic finish_head;
        logic read_link;
        logic finish_pop;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic found;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/ppa_ctrl.sv */
// Controller state machine of the per-CPU page allocator.
module ppa_ctrl
    import ppa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (dp_status.is_alloc && dp_status.found)
                begin
                    state_next = ST_LINK;
                end
                else if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LINK:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        dp_cmd    = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                dp_cmd.load = req_valid;
            end
            ST_DECODE:
            begin
                dp_cmd.decode = 1'b1;
            end
            ST_HEAD:
            begin
                if (dp_status.is_alloc && dp_status.found)
                begin
                    dp_cmd.read_link = 1'b1;
                end
                else
                begin
                    dp_cmd.finish_head = dp_status.out_free;
                end
            end
            ST_LINK:
            begin
                dp_cmd.finish_pop = dp_status.out_free;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/ppa_datapath.sv */
// Datapath of the per-CPU page allocator: config, list heads, link store, result.
module ppa_datapath
    import ppa_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  req_item_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp,
    input  dp_cmd_t              dp_cmd,
    output dp_status_t           dp_status
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int LINK_W = IDX_W + 1;
    localparam int PN_W   = 32 - PAGE_SHIFT;
    localparam int SUM_W  = (PN_W > IDX_W) ? PN_W : IDX_W;

    // Fold a CPU number into range by repeated subtraction
    function automatic logic [CPU_W-1:0] fold_cpu(input logic [2:0] c);
        logic [6:0] v;
        v = 7'(c);
        for (int k = 0; k < 8; k++)
        begin
            if (v >= 7'(NUM_CPUS))
            begin
                v = v - 7'(NUM_CPUS);
            end
        end
        return CPU_W'(v);
    endfunction

    // Configuration and control registers
    logic [31:0]         mem_start_reg, mem_start_next;
    logic [31:0]         mem_stop_reg, mem_stop_next;
    logic [NUM_CPUS-1:0] nonempty_reg, nonempty_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Request and decode registers
    logic                func_reg, func_next;
    logic [CPU_W-1:0]    cpu_reg, cpu_next;
    logic [31:0]         pa_reg, pa_next;
    logic                bad_reg, bad_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CPU_W-1:0]    src_reg, src_next;
    logic                found_reg, found_next;
    rsp_item_t           rsp_reg, rsp_next;

    // Memories and their read registers
    logic [IDX_W-1:0]    head_mem [NUM_CPUS];
    logic [LINK_W-1:0]   link_mem [NUM_PAGES];
    logic [IDX_W-1:0]    head_rd_reg;
    logic [LINK_W-1:0]   link_rd_reg;

    logic                head_we;
    logic [CPU_W-1:0]    head_waddr;
    logic [IDX_W-1:0]    head_wdata;
    logic                link_we;
    logic [LINK_W-1:0]   link_wdata;
    logic [CPU_W-1:0]    head_raddr;

    logic [CPU_W-1:0]    low_cpu;
    logic [CPU_W-1:0]    pick_cpu;
    logic [31:0]         diff;
    logic [31:0]         diff_pages;
    logic                out_free;
    logic                free_ok;
    logic [PN_W-1:0]     base_pn;
    logic [SUM_W-1:0]    addr_sum;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Pick the lowest non-empty list
    always_comb
    begin
        low_cpu = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                low_cpu = CPU_W'(i);
            end
        end
    end

    assign pick_cpu   = nonempty_reg[cpu_reg] ? cpu_reg : low_cpu;
    assign head_raddr = (func_reg == FUNC_ALLOC) ? pick_cpu : cpu_reg;

    // Page index relative to mem_start
    assign diff       = pa_reg - mem_start_reg;
    assign diff_pages = diff >> PAGE_SHIFT;

    // Rebuild the page address from the rounded-up base
    assign base_pn  = mem_start_reg[31:PAGE_SHIFT] + PN_W'(|mem_start_reg[PAGE_SHIFT-1:0]);
    assign addr_sum = SUM_W'(base_pn) + SUM_W'(head_rd_reg);

    assign free_ok = (func_reg == FUNC_FREE) && !bad_reg;

    // Next values
    always_comb
    begin
        mem_start_next = mem_start_reg;
        mem_stop_next  = mem_stop_reg;
        nonempty_next  = nonempty_reg;
        rsp_valid_next = rsp_valid_reg;
        func_next      = func_reg;
        cpu_next       = cpu_reg;
        pa_next        = pa_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        head_we        = 1'b0;
        head_waddr     = cpu_reg;
        head_wdata     = idx_reg;
        link_we        = 1'b0;
        link_wdata     = '0;

        // Write configuration
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEM_START: mem_start_next = cfg_data;
                CFG_MEM_STOP:  mem_stop_next  = cfg_data;
                default:       mem_start_next = mem_start_reg;
            endcase
        end

        // Drop the result once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // Latch the item
        if (dp_cmd.load)
        begin
            func_next = req.func;
            cpu_next  = fold_cpu(req.cpu_id);
            pa_next   = req.page_addr;
        end

        // Check the address and choose the source list
        if (dp_cmd.decode)
        begin
            bad_next = (pa_reg[PAGE_SHIFT-1:0] != '0) || (pa_reg < mem_start_reg)
                || (pa_reg >= mem_stop_reg) || (diff_pages >= 32'(NUM_PAGES));
            idx_next   = IDX_W'(diff_pages);
            src_next   = pick_cpu;
            found_next = |nonempty_reg;
        end

        // Push a page or report a bad free or no memory
        if (dp_cmd.finish_head)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.alloc_addr = '0;
            if (func_reg == FUNC_ALLOC)
            begin
                rsp_next.status = STATUS_NO_MEM;
            end
            else if (bad_reg)
            begin
                rsp_next.status = STATUS_BAD;
            end
            else
            begin
                rsp_next.status = STATUS_OK;
            end
            if (free_ok)
            begin
                link_we    = 1'b1;
                link_wdata = nonempty_reg[cpu_reg] ? ({1'b0, head_rd_reg} + LINK_W'(1)) : '0;
                head_we    = 1'b1;
                head_waddr = cpu_reg;
                head_wdata = idx_reg;
                nonempty_next[cpu_reg] = 1'b1;
            end
        end

        // Pop the head page of the source list
        if (dp_cmd.finish_pop)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = STATUS_OK;
            rsp_next.alloc_addr = {addr_sum[PN_W-1:0], {PAGE_SHIFT{1'b0}}};
            if (link_rd_reg == '0)
            begin
                nonempty_next[src_reg] = 1'b0;
            end
            else
            begin
                head_we    = 1'b1;
                head_waddr = src_reg;
                head_wdata = IDX_W'(link_rd_reg - LINK_W'(1));
            end
        end
    end

    // Hold control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg <= '0;
            mem_stop_reg  <= '0;
            nonempty_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mem_start_reg <= mem_start_next;
            mem_stop_reg  <= mem_stop_next;
            nonempty_reg  <= nonempty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        cpu_reg   <= cpu_next;
        pa_reg    <= pa_next;
        bad_reg   <= bad_next;
        idx_reg   <= idx_next;
        src_reg   <= src_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    // List head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (dp_cmd.decode)
        begin
            head_rd_reg <= head_mem[head_raddr];
        end
    end

    // Next-link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[idx_reg] <= link_wdata;
        end
        if (dp_cmd.read_link)
        begin
            link_rd_reg <= link_mem[head_rd_reg];
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign rsp                = rsp_reg;
    assign dp_status.is_alloc = (func_reg == FUNC_ALLOC);
    assign dp_status.found    = found_reg;
    assign dp_status.out_free = out_free;

endmodule

/* hw/rtl/per_cpu_page_allocator_unit.sv */
// Top level of the per-CPU page allocator: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  req      | req_valid/req_stall  | req_item_t: func, cpu_id, page_addr
//  rsp      | rsp_valid/rsp_stall  | rsp_item_t: status, alloc_addr
//  cfg      | cfg_we               | cfg_index, cfg_data (mem_start, mem_stop)
//
// A free or an out-of-memory allocate goes through the decode and head states;
// an allocate that pops adds the link state. They cover the registered read of
// the list head memory followed by the registered read of the next-link memory.
// Reset empties every list at once; the link store needs no clearing pass.
// A result waits in the output register while the next item is accepted; an
// item finishes only once that register is free.
module per_cpu_page_allocator_unit
    import ppa_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequence each item
    ppa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Hold lists, links and the result
    ppa_datapath #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

endmodule

/* dv/tb_per_cpu_page_allocator_unit.sv */
// Self-checking testbench of the per-CPU page allocator: free/alloc traffic against a predictor.
module tb_per_cpu_page_allocator_unit
    import ppa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_CPUS    = 8;
    localparam int          NUM_PAGES   = 32768;
    localparam int          PAGE_SHIFT  = 12;
    localparam int unsigned PAGE_SIZE   = 1 << PAGE_SHIFT;
    localparam logic [31:0] PAGE_MASK   = PAGE_SIZE - 1;
    localparam int          CHUNK_PAGES = 48;
    localparam int          HOLD_CYCLES = 80;
    localparam int          QUIET_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MEM_START;
    logic [31:0]          cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_item_t            req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_item_t            rsp;

    // Predictor state: window registers, per-CPU list tops, link store
    logic [31:0]         base_reg  = '0;
    logic [31:0]         limit_reg = '0;
    logic [14:0]         list_top [NUM_CPUS];
    logic [NUM_CPUS-1:0] list_full = '0;
    logic [15:0]         page_link [NUM_PAGES];

    req_item_t pending_reqs[$];
    rsp_item_t pending_results[$];

    logic calm          = 1'b0;
    int   hold_requests = 0;
    int   holds_done    = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   n_errors      = 0;
    int   n_pushed      = 0;
    int   n_rejected    = 0;
    int   n_popped      = 0;
    int   n_stolen      = 0;
    int   n_oom         = 0;
    int   n_settings    = 0;

    per_cpu_page_allocator_unit #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Address of the first managed page: window base rounded up to a page
    function automatic logic [63:0] page_base();
        return ({32'd0, base_reg} + 64'(PAGE_MASK)) & ~64'(PAGE_MASK);
    endfunction

    function automatic logic [31:0] page_at(int unsigned k);
        return 32'(page_base() + (64'(k) << PAGE_SHIFT));
    endfunction

    // Number of pages that a free can push under the current window
    function automatic int unsigned usable_pages();
        logic [63:0] first;
        logic [63:0] span;
        first = page_base();
        if (first >= {32'd0, limit_reg})
            return 0;
        span = ({32'd0, limit_reg} - first + 64'(PAGE_MASK)) >> PAGE_SHIFT;
        return (span > NUM_PAGES) ? NUM_PAGES : int'(span);
    endfunction

    // Apply one request to the allocator state and return its result
    function automatic rsp_item_t predict_page_result(req_item_t r);
        rsp_item_t   res;
        logic [2:0]  cpu;
        logic [2:0]  src;
        logic [31:0] idx;
        logic [14:0] top;
        logic [15:0] nxt;
        logic        bad;
        logic        found;
        int          i;
        res.status     = STATUS_OK;
        res.alloc_addr = '0;
        cpu            = r.cpu_id;
        if (r.func == FUNC_FREE)
        begin
            bad = (r.page_addr & PAGE_MASK) != 0 || r.page_addr < base_reg
                  || r.page_addr >= limit_reg;
            idx = (r.page_addr - base_reg) >> PAGE_SHIFT;
            if (!bad && idx >= NUM_PAGES)
                bad = 1'b1;
            if (bad)
            begin
                res.status = STATUS_BAD;
                n_rejected++;
            end
            else
            begin
                page_link[idx[14:0]] = list_full[cpu] ? {1'b0, list_top[cpu]} + 16'd1 : 16'd0;
                list_top[cpu]  = idx[14:0];
                list_full[cpu] = 1'b1;
                n_pushed++;
            end
        end
        else
        begin
            // Own list first, else steal from the lowest-numbered non-empty list
            src   = cpu;
            found = list_full[cpu];
            for (i = 0; i < NUM_CPUS; i++)
            begin
                if (!found && i != cpu && list_full[i])
                begin
                    src   = 3'(i);
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                res.status = STATUS_NO_MEM;
                n_oom++;
            end
            else
            begin
                if (src != cpu)
                    n_stolen++;
                else
                    n_popped++;
                top = list_top[src];
                nxt = page_link[top];
                if (nxt == 16'd0)
                begin
                    list_full[src] = 1'b0;
                    list_top[src]  = '0;
                end
                else
                begin
                    nxt           = nxt - 16'd1;
                    list_top[src] = nxt[14:0];
                end
                res.alloc_addr = page_at(top);
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        n_errors++;
    endtask

    task automatic queue_item(logic func, logic [2:0] cpu, logic [31:0] addr);
        req_item_t it;
        it.func      = func;
        it.cpu_id    = cpu;
        it.page_addr = addr;
        pending_reqs.push_back(it);
    endtask

    // Addresses near the edges of the window, mostly rejected
    function automatic logic [31:0] stray_addr();
        case ($urandom_range(4))
            0:       return $urandom();
            1:       return page_at($urandom_range(63)) + 32'($urandom_range(1, PAGE_SIZE - 1));
            2:       return base_reg - 32'($urandom_range(1, 2 * PAGE_SIZE));
            3:       return $urandom_range(1) ? limit_reg : (limit_reg + PAGE_MASK) & ~PAGE_MASK;
            default: return page_at(NUM_PAGES);
        endcase
    endfunction

    // Hold until every queued item has gone through and its result came back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Pop every list dry so that fresh pages can be freed again
    task automatic empty_lists();
        for (int r = 0; r < 8 && list_full != '0; r++)
        begin
            for (int j = 0; j < 16; j++)
                queue_item(FUNC_ALLOC, 3'($urandom_range(NUM_CPUS - 1)), $urandom());
            wait_drained();
        end
    endtask

    // Write both window registers while the block is idle
    task automatic set_window(logic [31:0] lo, logic [31:0] hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MEM_START;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MEM_STOP;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_reg  = lo;
        limit_reg = hi;
        n_settings++;
        @(negedge clk);
    endtask

    // Random traffic: bursts of varying alloc share, distinct pages per chunk
    task automatic queue_random(int unsigned count);
        int unsigned span;
        int unsigned chunk;
        int unsigned cursor;
        int unsigned fresh;
        int unsigned alloc_pct;
        logic [2:0]  cpu;
        span      = usable_pages();
        chunk     = (span < CHUNK_PAGES) ? span : CHUNK_PAGES;
        cursor    = (span != 0) ? $urandom_range(span - 1) : 0;
        fresh     = 0;
        alloc_pct = 50;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                alloc_pct = $urandom_range(20, 75);
            cpu = 3'($urandom_range(NUM_CPUS - 1));
            if ($urandom_range(99) < alloc_pct)
                queue_item(FUNC_ALLOC, cpu, $urandom());
            else if (span != 0 && $urandom_range(99) < 85)
            begin
                if (fresh == chunk)
                begin
                    wait_drained();
                    empty_lists();
                    fresh = 0;
                end
                queue_item(FUNC_FREE, cpu, page_at(cursor));
                cursor = (cursor + 1) % span;
                fresh++;
            end
            else
                queue_item(FUNC_FREE, cpu, stray_addr());
        end
    endtask

    // Request driver: advance to the next item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || !req_stall)
        begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 20))
            begin
                req_valid <= 1'b1;
                req       <= pending_reqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            rsp_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else
            rsp_stall <= !calm && ($urandom_range(99) < 20);
    end

    // Monitor: check results in order, predict each accepted request
    always @(posedge clk)
    begin : check_ports
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with none pending", '0, rsp.alloc_addr);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(rsp.status));
                    if (rsp.alloc_addr !== want.alloc_addr)
                        flag_mismatch("alloc_addr", want.alloc_addr, rsp.alloc_addr);
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(predict_page_result(req));
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: window edges, rejects, own pops, steals, out of memory
        set_window(32'h8000_0000, 32'h8800_2000);
        queue_item(FUNC_ALLOC, 3'd0, 32'hFFFF_FFFF);
        queue_item(FUNC_FREE, 3'd0, page_at(0));
        queue_item(FUNC_FREE, 3'd7, page_at(NUM_PAGES - 1));
        queue_item(FUNC_FREE, 3'd3, page_at(5) + 32'd1);
        queue_item(FUNC_FREE, 3'd3, base_reg - PAGE_SIZE);
        queue_item(FUNC_FREE, 3'd6, page_at(NUM_PAGES));
        queue_item(FUNC_FREE, 3'd1, 32'hFFFF_FFFF);
        queue_item(FUNC_FREE, 3'd2, 32'h0000_0000);
        queue_item(FUNC_ALLOC, 3'd0, 32'h0000_0000);
        queue_item(FUNC_ALLOC, 3'd5, 32'h5555_5555);
        queue_item(FUNC_ALLOC, 3'd2, 32'hAAAA_AAAA);
        queue_item(FUNC_FREE, 3'd1, page_at(1));
        queue_item(FUNC_FREE, 3'd1, page_at(2));
        queue_item(FUNC_FREE, 3'd4, page_at(3));
        queue_item(FUNC_ALLOC, 3'd1, '0);
        queue_item(FUNC_ALLOC, 3'd1, '0);
        queue_item(FUNC_ALLOC, 3'd1, '0);
        queue_item(FUNC_ALLOC, 3'd1, '0);
        // Same page freed on two CPUs: both lists hand it out
        queue_item(FUNC_FREE, 3'd2, page_at(5));
        queue_item(FUNC_FREE, 3'd3, page_at(5));
        queue_item(FUNC_ALLOC, 3'd2, '0);
        queue_item(FUNC_ALLOC, 3'd6, '0);
        queue_item(FUNC_ALLOC, 3'd6, '0);
        wait_drained();

        // Empty window: every free is rejected
        set_window(32'h0000_0000, 32'h0000_0000);
        queue_random(30);
        wait_drained();

        // Small unaligned window: frequent steals and out of memory
        set_window(32'h0000_1234, 32'h0004_0000);
        queue_random(300);
        wait_drained();
        empty_lists();

        // Whole address space: page index limit reachable
        set_window(32'h0000_0000, 32'hFFFF_FFFF);
        queue_random(250);
        wait_drained();
        empty_lists();

        // Top of memory; leave pages listed across the next window change
        set_window(32'hFFFF_0001, 32'hFFFF_FFFF);
        queue_random(120);
        wait_drained();

        // Base rounds past 4 GiB: addresses of listed pages wrap
        set_window(32'hFFFF_F001, 32'hFFFF_FFFF);
        queue_random(50);
        wait_drained();

        // Back-pressure: calm stretch, long receiver hold-off, then full idling
        set_window(32'h1000_0000, 32'h2000_0000);
        calm = 1'b1;
        hold_requests++;
        queue_random(150);
        wait_drained();
        calm = 1'b0;
        queue_random(300);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Ran %0d window settings: %0d pages pushed, %0d frees rejected",
                 n_settings, n_pushed, n_rejected);
        $display("Allocations: %0d from own list, %0d stolen, %0d out of memory",
                 n_popped, n_stolen, n_oom);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
